>>> hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

   // Raw bytes kept for a pending \u escape: at most "\u" plus three digits
   // of a second escape, plus the byte being written.
   localparam int unsigned HELD_DEPTH = 6;
   localparam int unsigned HIDX_W     = $clog2(HELD_DEPTH);

   // Bytes one step of the decoder can produce (high surrogate + one code).
   localparam int unsigned EMIT_DEPTH = 6;
   localparam int unsigned EIDX_W     = $clog2(EMIT_DEPTH + 1);

   // Result items kept per input item.
   localparam int unsigned STEP_MAX = 8;
   localparam int unsigned STEP_W   = $clog2(STEP_MAX + 1);

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;

   localparam logic [15:0] SURR_HI_MIN = 16'hD800;
   localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
   localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
   localparam logic [20:0] PLANE1_BASE = 21'h10000;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   typedef struct packed {
      logic [EMIT_DEPTH-1:0][7:0] data;
      logic [EIDX_W-1:0]          cnt;
   } emit_list_type;

   typedef struct packed {
      logic load;         // latch the accepted item
      logic feed;         // run one byte through the decoder
      logic feed_replay;  // take that byte from the replay buffer
      logic fin;          // one end-of-string round
      logic emit;         // move one decoded byte toward the output
      logic flush;        // release the held-back byte, close the item
   } dp_cmd_type;

   typedef struct packed {
      logic buf_empty;
      logic replay_left;
      logic last;
      logic term;
      logic emit_ok;
   } dp_status_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Value of the leading hex digits; b[0] is the first byte.
   function automatic logic [15:0] hex4(logic [3:0][7:0] b);
      logic [15:0] v;
      logic        stop;
      logic [4:0]  d;
      v    = '0;
      stop = 1'b0;
      for (int i = 0; i < 4; i++) begin
         d = hex_digit(b[i]);
         if (!stop && d[4]) begin
            v = {v[11:0], d[3:0]};
         end else begin
            stop = 1'b1;
         end
      end
      return v;
   endfunction

   function automatic emit_list_type emit_add(emit_list_type e, logic [7:0] b);
      emit_list_type r;
      r = e;
      if (e.cnt < EIDX_W'(EMIT_DEPTH)) begin
         r.data[e.cnt] = b;
         r.cnt         = e.cnt + 1'b1;
      end
      return r;
   endfunction

   function automatic emit_list_type emit_bmp(emit_list_type e, logic [15:0] cp);
      emit_list_type r;
      if (cp < 16'h0080) begin
         r = emit_add(e, cp[7:0]);
      end else if (cp < 16'h0800) begin
         r = emit_add(e, UTF8_LEAD2 | {3'b000, cp[10:6]});
         r = emit_add(r, UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
         r = emit_add(e, UTF8_LEAD3 | {4'b0000, cp[15:12]});
         r = emit_add(r, UTF8_CONT | {2'b00, cp[11:6]});
         r = emit_add(r, UTF8_CONT | {2'b00, cp[5:0]});
      end
      return r;
   endfunction

   function automatic emit_list_type emit_pair(emit_list_type e, logic [15:0] hi,
                                               logic [15:0] lo);
      emit_list_type r;
      logic [20:0]   cp;
      cp = PLANE1_BASE + {1'b0, hi[9:0], lo[9:0]};
      r  = emit_add(e, UTF8_LEAD4 | {5'b00000, cp[20:18]});
      r  = emit_add(r, UTF8_CONT | {2'b00, cp[17:12]});
      r  = emit_add(r, UTF8_CONT | {2'b00, cp[11:6]});
      r  = emit_add(r, UTF8_CONT | {2'b00, cp[5:0]});
      return r;
   endfunction

endpackage

>>> hw/rtl/jsu_datapath.sv
`timescale 1ns / 1ps
module jsu_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  jsu_pkg::dp_cmd_type    cmd,
   output jsu_pkg::dp_status_type status,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_first,
   input  logic                   req_last,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ESC,
      MODE_HEX,
      MODE_PAIR_BS,
      MODE_PAIR_U,
      MODE_PAIR_HEX
   } mode_type;

   // control state
   mode_type                       mode_ff, mode_in;
   logic [jsu_pkg::HIDX_W-1:0]     held_cnt_ff, held_cnt_in;
   logic [15:0]                    high_ff, high_in;
   logic [jsu_pkg::HIDX_W-1:0]     rep_n_ff, rep_n_in;
   logic [jsu_pkg::HIDX_W-1:0]     rep_idx_ff, rep_idx_in;
   jsu_pkg::emit_list_type         ebuf_ff, ebuf_in;
   logic [jsu_pkg::EIDX_W-1:0]     eidx_ff, eidx_in;
   logic                           term_ff, term_in;
   logic [jsu_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           last_ff, last_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // payload
   logic [7:0] held_ff [jsu_pkg::HELD_DEPTH];
   logic [7:0] held_in [jsu_pkg::HELD_DEPTH];
   logic [7:0] rep_ff  [jsu_pkg::HELD_DEPTH];
   logic [7:0] rep_in  [jsu_pkg::HELD_DEPTH];
   logic [7:0] byte_ff, byte_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   // decoder step results
   logic [7:0]                 c;
   mode_type                   f_mode;
   logic [jsu_pkg::HIDX_W-1:0] f_cnt;
   logic                       f_wr;
   logic [15:0]                f_high;
   jsu_pkg::emit_list_type     f_emit;
   logic [15:0]                hex_a, hex_b;
   logic [7:0]                 esc_byte;
   jsu_pkg::emit_list_type     fin_emit;
   logic                       fin_term;

   assign hex_a = jsu_pkg::hex4({c, held_ff[2], held_ff[1], held_ff[0]});
   assign hex_b = jsu_pkg::hex4({c, held_ff[4], held_ff[3], held_ff[2]});

   always_comb begin
      case (c)
         jsu_pkg::CH_N: esc_byte = jsu_pkg::CH_LF;
         jsu_pkg::CH_R: esc_byte = jsu_pkg::CH_CR;
         jsu_pkg::CH_T: esc_byte = jsu_pkg::CH_TAB;
         jsu_pkg::CH_B: esc_byte = jsu_pkg::CH_BS;
         jsu_pkg::CH_F: esc_byte = jsu_pkg::CH_FF;
         default:       esc_byte = c;
      endcase
   end

   // one byte through the decoder
   always_comb begin
      c      = cmd.feed_replay ? rep_ff[rep_idx_ff] : byte_ff;
      f_mode = MODE_IDLE;
      f_cnt  = '0;
      f_wr   = 1'b0;
      f_high = high_ff;
      f_emit = '0;
      case (mode_ff)
         MODE_ESC: begin
            if (c == jsu_pkg::CH_U) begin
               f_mode = MODE_HEX;
            end else begin
               f_emit = jsu_pkg::emit_add(f_emit, esc_byte);
            end
         end
         MODE_HEX: begin
            f_wr  = 1'b1;
            f_cnt = held_cnt_ff + 1'b1;
            f_mode = MODE_HEX;
            if (held_cnt_ff == jsu_pkg::HIDX_W'(3)) begin
               f_cnt = '0;
               if (hex_a >= jsu_pkg::SURR_HI_MIN && hex_a <= jsu_pkg::SURR_HI_MAX) begin
                  f_high = hex_a;
                  f_mode = MODE_PAIR_BS;
               end else begin
                  f_emit = jsu_pkg::emit_bmp(f_emit, hex_a);
                  f_mode = MODE_IDLE;
               end
            end
         end
         MODE_PAIR_BS: begin
            if (c == jsu_pkg::CH_BSLASH) begin
               f_wr   = 1'b1;
               f_cnt  = jsu_pkg::HIDX_W'(1);
               f_mode = MODE_PAIR_U;
            end else begin
               f_emit = jsu_pkg::emit_bmp(f_emit, high_ff);
               f_emit = jsu_pkg::emit_add(f_emit, c);
            end
         end
         MODE_PAIR_U: begin
            if (c == jsu_pkg::CH_U) begin
               f_wr   = 1'b1;
               f_cnt  = held_cnt_ff + 1'b1;
               f_mode = MODE_PAIR_HEX;
            end else begin
               f_emit = jsu_pkg::emit_bmp(f_emit, high_ff);
               f_emit = jsu_pkg::emit_add(f_emit, esc_byte);
            end
         end
         MODE_PAIR_HEX: begin
            f_wr   = 1'b1;
            f_cnt  = held_cnt_ff + 1'b1;
            f_mode = MODE_PAIR_HEX;
            if (held_cnt_ff == jsu_pkg::HIDX_W'(5)) begin
               f_cnt = '0;
               if (hex_b >= jsu_pkg::SURR_LO_MIN && hex_b <= jsu_pkg::SURR_LO_MAX) begin
                  f_emit = jsu_pkg::emit_pair(f_emit, high_ff, hex_b);
                  f_mode = MODE_IDLE;
               end else begin
                  f_emit = jsu_pkg::emit_bmp(f_emit, high_ff);
                  if (hex_b >= jsu_pkg::SURR_HI_MIN && hex_b <= jsu_pkg::SURR_HI_MAX) begin
                     f_high = hex_b;
                     f_mode = MODE_PAIR_BS;
                  end else begin
                     f_emit = jsu_pkg::emit_bmp(f_emit, hex_b);
                     f_mode = MODE_IDLE;
                  end
               end
            end
         end
         default: begin
            if (c == jsu_pkg::CH_BSLASH) begin
               f_mode = MODE_ESC;
            end else begin
               f_emit = jsu_pkg::emit_add(f_emit, c);
            end
         end
      endcase
   end

   // one end-of-string round
   always_comb begin
      fin_emit = '0;
      fin_term = 1'b1;
      case (mode_ff)
         MODE_ESC:      fin_emit = jsu_pkg::emit_add(fin_emit, jsu_pkg::CH_BSLASH);
         MODE_PAIR_BS:  fin_emit = jsu_pkg::emit_bmp(fin_emit, high_ff);
         MODE_HEX: begin
            fin_emit = jsu_pkg::emit_add(fin_emit, jsu_pkg::CH_U);
            fin_term = 1'b0;
         end
         MODE_PAIR_U, MODE_PAIR_HEX: begin
            fin_emit = jsu_pkg::emit_bmp(fin_emit, high_ff);
            fin_term = 1'b0;
         end
         default:       fin_term = 1'b1;
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      held_cnt_in   = held_cnt_ff;
      high_in       = high_ff;
      rep_n_in      = rep_n_ff;
      rep_idx_in    = rep_idx_ff;
      ebuf_in       = ebuf_ff;
      eidx_in       = eidx_ff;
      term_in       = term_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      held_in       = held_ff;
      rep_in        = rep_ff;
      byte_in       = byte_ff;
      pend_byte_in  = pend_byte_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load) begin
         byte_in = req_in_byte;
         last_in = req_last;
         step_in = '0;
         if (req_first) begin
            mode_in     = MODE_IDLE;
            held_cnt_in = '0;
            high_in     = '0;
         end
      end

      if (cmd.feed) begin
         mode_in     = f_mode;
         held_cnt_in = f_cnt;
         high_in     = f_high;
         ebuf_in     = f_emit;
         eidx_in     = '0;
         if (f_wr) begin
            held_in[held_cnt_ff] = c;
         end
         if (cmd.feed_replay) begin
            rep_idx_in = rep_idx_ff + 1'b1;
         end
      end

      if (cmd.fin) begin
         mode_in     = MODE_IDLE;
         held_cnt_in = '0;
         term_in     = fin_term;
         ebuf_in     = fin_emit;
         eidx_in     = '0;
         rep_in      = held_ff;
         rep_idx_in  = '0;
         rep_n_in    = fin_term ? '0 : held_cnt_ff;
      end

      if (cmd.emit) begin
         eidx_in = eidx_ff + 1'b1;
         // past the per-item limit the byte is dropped
         if (step_ff < jsu_pkg::STEP_W'(jsu_pkg::STEP_MAX)) begin
            step_in       = step_ff + 1'b1;
            pend_valid_in = 1'b1;
            pend_byte_in  = ebuf_ff.data[eidx_ff];
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_byte_ff;
               rsp_last_in  = 1'b0;
            end
         end
      end

      if (cmd.flush && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = pend_byte_ff;
         rsp_last_in   = last_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_cnt_ff   <= '0;
         high_ff       <= '0;
         rep_n_ff      <= '0;
         rep_idx_ff    <= '0;
         ebuf_ff       <= '0;
         eidx_ff       <= '0;
         term_ff       <= 1'b0;
         step_ff       <= '0;
         last_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         held_cnt_ff   <= held_cnt_in;
         high_ff       <= high_in;
         rep_n_ff      <= rep_n_in;
         rep_idx_ff    <= rep_idx_in;
         ebuf_ff       <= ebuf_in;
         eidx_ff       <= eidx_in;
         term_ff       <= term_in;
         step_ff       <= step_in;
         last_ff       <= last_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff      <= held_in;
      rep_ff       <= rep_in;
      byte_ff      <= byte_in;
      pend_byte_ff <= pend_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.buf_empty   = (eidx_ff == ebuf_ff.cnt);
   assign status.replay_left = (rep_idx_ff != rep_n_ff);
   assign status.last        = last_ff;
   assign status.term        = term_ff;
   assign status.emit_ok     = !pend_valid_ff || !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

>>> hw/rtl/jsu_ctrl.sv
`timescale 1ns / 1ps
module jsu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  jsu_pkg::dp_status_type status,
   output jsu_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_REPLAY,
      ST_FINISH,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               fin_in   = 1'b0;
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            cmd.feed = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_REPLAY: begin
            cmd.feed        = 1'b1;
            cmd.feed_replay = 1'b1;
            state_in        = ST_DRAIN;
         end
         ST_FINISH: begin
            cmd.fin  = 1'b1;
            fin_in   = 1'b1;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.buf_empty) begin
               cmd.emit = status.emit_ok;
            end else if (fin_ff) begin
               if (status.replay_left) begin
                  state_in = ST_REPLAY;
               end else if (status.term) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (status.last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.emit_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

>>> hw/rtl/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// JSON string unescaper: content bytes of a quoted string in, unescaped
// UTF-8 bytes out.
// Input channel (req_*): one raw byte per item; req_first opens a new string
//   and drops any pending escape, req_last closes it and flushes what is held.
// Output channel (rsp_*): one byte per item; rsp_out_last marks the final byte
//   caused by an input item that carried req_last. At most 8 bytes per input.
// Sequencing: one item is worked at a time. A decoder step produces 0 to 6
//   bytes, which leave over a single byte-wide emit path; an item with
//   req_last adds end-of-string rounds and replays held bytes (a short \u at the
//   end of the string is replayed as plain text).
// Output: the first byte of an item is released once a second byte of that
//   item is emitted, otherwise when the item closes;
//   the last byte of an item is held back until the item closes so it can be
//   tagged.
// Reset: synchronous, active high; the decoder returns to plain content, the
//   output register empties and req_stall drops in the next cycle.
// Back-pressure: while rsp_stall is high the output register holds its byte
//   and a held-back byte waits; req_stall stays high until the item is closed.
module json_string_unescape_utf8_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_first,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   jsu_pkg::dp_cmd_type    cmd;
   jsu_pkg::dp_status_type status;

   // sequencer: accept, feed, drain, end-of-string rounds, replay, close
   jsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // decoder state, emit buffer, held-back byte and output register
   jsu_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_in_byte  (req_in_byte),
      .req_first    (req_first),
      .req_last     (req_last),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

>>> hw/rtl/jsu_checker.sv
`timescale 1ns / 1ps
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // reset empties the output and opens the input
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or stall not cleared after reset");

   // one item at a time: an accepted item closes the input
   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an accepted item");

   // a stalled output item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("stalled output item changed");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import jsu_pkg::*;

   // Slots of the predictor's escape hold buffer; only the first six are ever used.
   localparam int HOLD_SLOTS    = 12;
   // Give up long after the slowest legal run would have finished.
   localparam int CYCLE_LIMIT   = 400000;
   // Cycles allowed after the last expected byte for stray output to show up.
   localparam int SETTLE_CYCLES = 40;
   // Target of random input items for each idling phase.
   localparam int PHASE_ITEMS   = 100;

   typedef enum logic [2:0] {
      DEC_PLAIN,
      DEC_ESC,
      DEC_HEX,
      DEC_PAIR_BS,
      DEC_PAIR_U,
      DEC_PAIR_HEX
   } dec_mode_e;

   // Predict the unescaped byte stream and check what the block sends.
   class unescape_scoreboard;
      dec_mode_e   mode;
      logic [7:0]  held [HOLD_SLOTS];
      int          held_n;
      logic [15:0] hi_surr;
      logic [7:0]  step_bytes [$];
      logic [8:0]  pending_utf8 [$];   // {out_last, out_byte}
      int          mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         mode    = DEC_PLAIN;
         held_n  = 0;
         hi_surr = '0;
         foreach (held[i]) held[i] = '0;
      endfunction

      function void put(logic [7:0] b);
         if (step_bytes.size() < 16) step_bytes.push_back(b);
      endfunction

      function void hold_byte(logic [7:0] c);
         if (held_n < HOLD_SLOTS) begin
            held[held_n] = c;
            held_n++;
         end
      endfunction

      function int hex_nib(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         return -1;
      endfunction

      // Value of the leading hex digits among four held bytes from slot 'at'.
      function logic [15:0] hex_at(int at);
         logic [15:0] v;
         int          d;
         v = '0;
         for (int i = 0; i < 4; i++) begin
            d = hex_nib(held[(at + i) % HOLD_SLOTS]);
            if (d < 0) break;
            v = {v[11:0], 4'(d)};
         end
         return v;
      endfunction

      function void put_bmp(logic [15:0] cp);
         if (cp < 16'h0080) begin
            put(cp[7:0]);
         end else if (cp < 16'h0800) begin
            put(UTF8_LEAD2 | {3'b000, cp[10:6]});
            put(UTF8_CONT | {2'b00, cp[5:0]});
         end else begin
            put(UTF8_LEAD3 | {4'b0000, cp[15:12]});
            put(UTF8_CONT | {2'b00, cp[11:6]});
            put(UTF8_CONT | {2'b00, cp[5:0]});
         end
      endfunction

      function void take_code(logic [15:0] cp);
         held_n = 0;
         if (cp >= SURR_HI_MIN && cp <= SURR_HI_MAX) begin
            hi_surr = cp;
            mode    = DEC_PAIR_BS;
         end else begin
            put_bmp(cp);
            mode = DEC_PLAIN;
         end
      endfunction

      function void escaped(logic [7:0] c);
         mode = DEC_PLAIN;
         case (c)
            CH_N: put(CH_LF);
            CH_R: put(CH_CR);
            CH_T: put(CH_TAB);
            CH_B: put(CH_BS);
            CH_F: put(CH_FF);
            CH_U: begin
               mode   = DEC_HEX;
               held_n = 0;
            end
            default: put(c);
         endcase
      endfunction

      function void feed(logic [7:0] c);
         logic [15:0] lo;
         logic [20:0] cp;
         case (mode)
            DEC_ESC: escaped(c);
            DEC_HEX: begin
               hold_byte(c);
               if (held_n >= 4) take_code(hex_at(0));
            end
            DEC_PAIR_BS: begin
               if (c == CH_BSLASH) begin
                  held_n = 0;
                  hold_byte(c);
                  mode = DEC_PAIR_U;
               end else begin
                  put_bmp(hi_surr);
                  held_n = 0;
                  mode   = DEC_PLAIN;
                  put(c);
               end
            end
            DEC_PAIR_U: begin
               if (c == CH_U) begin
                  hold_byte(c);
                  mode = DEC_PAIR_HEX;
               end else begin
                  put_bmp(hi_surr);
                  held_n = 0;
                  escaped(c);
               end
            end
            DEC_PAIR_HEX: begin
               hold_byte(c);
               if (held_n >= 6) begin
                  lo     = hex_at(2);
                  held_n = 0;
                  if (lo >= SURR_LO_MIN && lo <= SURR_LO_MAX) begin
                     cp = PLANE1_BASE + ({5'b0, hi_surr - SURR_HI_MIN} << 10)
                          + {5'b0, lo - SURR_LO_MIN};
                     put(UTF8_LEAD4 | {5'b00000, cp[20:18]});
                     put(UTF8_CONT | {2'b00, cp[17:12]});
                     put(UTF8_CONT | {2'b00, cp[11:6]});
                     put(UTF8_CONT | {2'b00, cp[5:0]});
                     mode = DEC_PLAIN;
                  end else begin
                     put_bmp(hi_surr);
                     take_code(lo);
                  end
               end
            end
            default: begin
               mode = DEC_PLAIN;
               if (c == CH_BSLASH) mode = DEC_ESC;
               else put(c);
            end
         endcase
      endfunction

      // Flush whatever the string left pending; a short \u is replayed as text.
      function void flush_string();
         logic [7:0] replay [HOLD_SLOTS];
         int         n;
         for (int round = 0; round < 8; round++) begin
            case (mode)
               DEC_ESC: begin
                  put(CH_BSLASH);
                  mode = DEC_PLAIN;
                  return;
               end
               DEC_PAIR_BS: begin
                  put_bmp(hi_surr);
                  mode   = DEC_PLAIN;
                  held_n = 0;
                  return;
               end
               DEC_HEX, DEC_PAIR_U, DEC_PAIR_HEX: begin
                  if (mode == DEC_HEX) put(CH_U);
                  else put_bmp(hi_surr);
                  n = (held_n < HOLD_SLOTS) ? held_n : HOLD_SLOTS;
                  for (int i = 0; i < n; i++) replay[i] = held[i];
                  held_n = 0;
                  mode   = DEC_PLAIN;
                  for (int i = 0; i < n; i++) feed(replay[i]);
               end
               default: begin
                  mode = DEC_PLAIN;
                  return;
               end
            endcase
         end
      endfunction

      function void note_input(logic [7:0] b, logic first, logic last);
         int n;
         if (first) clear();
         step_bytes.delete();
         feed(b);
         if (last) begin
            flush_string();
            mode   = DEC_PLAIN;
            held_n = 0;
         end
         n = (step_bytes.size() < STEP_MAX) ? step_bytes.size() : STEP_MAX;
         for (int k = 0; k < n; k++) pending_utf8.push_back({last && k == n - 1, step_bytes[k]});
      endfunction

      function void check_output(logic [7:0] b, logic last);
         logic [8:0] want;
         if (pending_utf8.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h last %0b with nothing pending", b, last);
            return;
         end
         want = pending_utf8.pop_front();
         if (want[7:0] !== b || want[8] !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        want[7:0], want[8], b, last);
         end
      endfunction
   endclass

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte  = '0;
   logic       req_first    = 1'b0;
   logic       req_last     = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   unescape_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned cycle_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned idle_tab [4]  = '{0, 54, 0, 24};
   int unsigned stall_tab [4] = '{0, 0, 54, 24};

   // Raw content bytes of the string being sent.
   logic [7:0] raw_q [$];

   json_string_unescape_utf8_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_first   (req_first),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hang guard: abort if the run goes far beyond any legal length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Random back-pressure on the output, changed on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Watch both channels at the rising edge: note accepted input, check output.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_in_byte, req_first, req_last);
         if (rsp_valid && !rsp_stall) sb.check_output(rsp_out_byte, rsp_out_last);
      end
   end

   // Present one item at the falling edge, idle first at random, hold until taken.
   task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_first   <= f;
      req_last    <= l;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_string(input logic f, input logic l);
      foreach (raw_q[i]) send_byte(raw_q[i], f && i == 0, l && i == raw_q.size() - 1);
      items_sent += raw_q.size();
   endtask

   // Drop valid and hold off until every predicted byte has come out.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_utf8.size() != 0) @(posedge clock);
   endtask

   function void load_text(string s);
      raw_q.delete();
      for (int i = 0; i < s.len(); i++) raw_q.push_back(8'(s[i]));
   endfunction

   function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'("0") + 8'(nib);
      return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(nib - 4'd10);
   endfunction

   // Append \uXXXX; when mangled, one digit becomes an arbitrary byte.
   function void push_u(logic [15:0] v, bit mangle);
      logic [7:0] digs [4];
      for (int i = 0; i < 4; i++) digs[i] = hex_char(v[15 - 4 * i -: 4]);
      if (mangle) digs[$urandom_range(3)] = 8'($urandom_range(255));
      raw_q.push_back(CH_BSLASH);
      raw_q.push_back(CH_U);
      foreach (digs[i]) raw_q.push_back(digs[i]);
   endfunction

   // Append one lexical piece of string content, mostly well formed.
   function void add_token();
      int unsigned pick;
      logic [7:0]  b;
      pick = $urandom_range(99);
      if (pick < 40) begin
         // plain byte; a backslash goes out escaped
         b = 8'($urandom_range(255));
         raw_q.push_back(b);
         if (b == CH_BSLASH) raw_q.push_back(b);
      end else if (pick < 55) begin
         raw_q.push_back(CH_BSLASH);
         case ($urandom_range(7))
            0: raw_q.push_back(CH_N);
            1: raw_q.push_back(CH_R);
            2: raw_q.push_back(CH_T);
            3: raw_q.push_back(CH_B);
            4: raw_q.push_back(CH_F);
            5: raw_q.push_back(8'("\""));
            6: raw_q.push_back(8'("/"));
            default: raw_q.push_back(CH_BSLASH);
         endcase
      end else if (pick < 60) begin
         // any escaped byte; but for the named escapes and u, passed on without its backslash
         raw_q.push_back(CH_BSLASH);
         raw_q.push_back(8'($urandom_range(255)));
      end else if (pick < 80) begin
         case ($urandom_range(3))
            0: push_u(16'($urandom_range(16'h007F)), $urandom_range(9) == 0);
            1: push_u(16'($urandom_range(16'h07FF, 16'h0080)), $urandom_range(9) == 0);
            2: push_u(16'($urandom_range(16'hFFFF, 16'h0800)), $urandom_range(9) == 0);
            default: push_u(16'($urandom_range(16'hFFFF)), $urandom_range(9) == 0);
         endcase
      end else if (pick < 90) begin
         // surrogate pair
         push_u(SURR_HI_MIN + 16'($urandom_range(16'h03FF)), 1'b0);
         push_u(SURR_LO_MIN + 16'($urandom_range(16'h03FF)), 1'b0);
      end else if (pick < 95) begin
         // lone surrogate: a low one, or a high one followed by a byte, an escape, a random \u or nothing
         if ($urandom_range(1)) begin
            push_u(SURR_LO_MIN + 16'($urandom_range(16'h03FF)), 1'b0);
         end else begin
            push_u(SURR_HI_MIN + 16'($urandom_range(16'h03FF)), 1'b0);
            case ($urandom_range(3))
               0: raw_q.push_back(8'($urandom_range(255)));
               1: begin
                  raw_q.push_back(CH_BSLASH);
                  raw_q.push_back(8'($urandom_range(255)));
               end
               2: push_u(16'($urandom_range(16'hFFFF)), 1'b0);
               default: ;
            endcase
         end
      end else begin
         push_u(16'($urandom_range(16'hFFFF)), 1'b1);
      end
   endfunction

   task automatic send_random_string();
      int unsigned cut;
      logic        f;
      logic        l;
      raw_q.delete();
      repeat ($urandom_range(8, 1)) add_token();
      // cut the tail now and then: short \u and lone backslash at the end
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(5, 1);
         while (cut != 0 && raw_q.size() > 1) begin
            void'(raw_q.pop_back());
            cut--;
         end
      end
      f = ($urandom_range(9) != 0);
      l = ($urandom_range(6) != 0);
      send_string(f, l);
   endtask

   initial begin
      int unsigned phase_start;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes of the byte range
      raw_q = '{8'h00, 8'hFF};
      send_string(1'b1, 1'b1);
      // simple escape, two-byte code point, trailing backslash
      load_text("\\n\\u00e9\\");
      send_string(1'b1, 1'b1);
      // open \u dropped by the next string starting without a last
      load_text("\\u");
      send_string(1'b1, 1'b0);
      // high surrogate then a short \u at the end: replayed as text
      load_text("\\uD83D\\uDC0");
      send_string(1'b1, 1'b1);

      for (int p = 0; p < 4; p++) begin
         wait_drained();
         send_idle_pct = idle_tab[p];
         stall_pct     = stall_tab[p];
         phase_start   = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_string();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_utf8.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
